// ===== design/scrb_pkg.sv =====
package scrb_pkg;

    // ring geometry
    localparam int BUF_DEPTH = 256;
    localparam int PTR_W     = $clog2(BUF_DEPTH);
    localparam int CNT_W     = $clog2(BUF_DEPTH + 1);

    // field widths
    localparam int CHAR_W    = 7;
    localparam int CODE_W    = 8;
    localparam int FUNC_W    = 2;
    localparam int STAT_W    = 3;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 16;

    // special characters of the translation rom
    localparam logic [CHAR_W-1:0] CH_NONE     = 7'd0;
    localparam logic [CHAR_W-1:0] CH_UNMAPPED = 7'd4;
    localparam logic [CHAR_W-1:0] CH_BS       = 7'd8;
    localparam logic [CHAR_W-1:0] CH_ESC      = 7'd27;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_SCAN    = 2'd0,
        FUNC_CONSUME = 2'd1,
        FUNC_PEEK    = 2'd2,
        FUNC_NONE    = 2'd3
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        STAT_INVALID  = 3'd0,
        STAT_FULL     = 3'd1,
        STAT_DELETED  = 3'd2,
        STAT_STORED   = 3'd3,
        STAT_UNMAPPED = 3'd4
    } t_status;

    // memory access issued when a request is taken
    typedef struct packed {
        logic              we;
        logic [PTR_W-1:0]  waddr;
        logic [CHAR_W-1:0] wdata;
        logic              re;
        logic [PTR_W-1:0]  raddr;
    } t_mem_req;

    // result fields known at request time
    typedef struct packed {
        t_status status;
        logic    key_hit;
        logic    key_avail;
    } t_step_res;

    // pointer step forward around the ring
    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        if (p == PTR_W'(BUF_DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + PTR_W'(1);
        end
        return q;
    endfunction

    // pointer step back around the ring
    function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        if (p == '0) begin
            q = PTR_W'(BUF_DEPTH - 1);
        end else begin
            q = p - PTR_W'(1);
        end
        return q;
    endfunction

    // distance from base to p going forward around the ring
    function automatic logic [PTR_W-1:0] ptr_dist(input logic [PTR_W-1:0] p,
                                                  input logic [PTR_W-1:0] base);
        logic [PTR_W:0] d;
        if (p >= base) begin
            d = {1'b0, p} - {1'b0, base};
        end else begin
            d = {1'b0, p} + (PTR_W+1)'(BUF_DEPTH) - {1'b0, base};
        end
        return d[PTR_W-1:0];
    endfunction

    // scan code set 1 make-code table
    function automatic logic [CHAR_W-1:0] translate(input logic [CHAR_W-1:0] code);
        logic [CHAR_W-1:0] ch;
        case (code)
            7'd1:  ch = CH_ESC;
            7'd2:  ch = 7'd49;
            7'd3:  ch = 7'd50;
            7'd4:  ch = 7'd51;
            7'd5:  ch = 7'd52;
            7'd6:  ch = 7'd53;
            7'd7:  ch = 7'd54;
            7'd8:  ch = 7'd55;
            7'd9:  ch = 7'd56;
            7'd10: ch = 7'd57;
            7'd11: ch = 7'd48;
            7'd12: ch = 7'd45;
            7'd13: ch = 7'd61;
            7'd14: ch = CH_BS;
            7'd15: ch = 7'd9;
            7'd16: ch = 7'd113;
            7'd17: ch = 7'd119;
            7'd18: ch = 7'd101;
            7'd19: ch = 7'd114;
            7'd20: ch = 7'd116;
            7'd21: ch = 7'd121;
            7'd22: ch = 7'd117;
            7'd23: ch = 7'd105;
            7'd24: ch = 7'd111;
            7'd25: ch = 7'd112;
            7'd26: ch = 7'd91;
            7'd27: ch = 7'd93;
            7'd28: ch = 7'd10;
            7'd30: ch = 7'd97;
            7'd31: ch = 7'd115;
            7'd32: ch = 7'd100;
            7'd33: ch = 7'd102;
            7'd34: ch = 7'd103;
            7'd35: ch = 7'd104;
            7'd36: ch = 7'd106;
            7'd37: ch = 7'd107;
            7'd38: ch = 7'd108;
            7'd39: ch = 7'd59;
            7'd40: ch = 7'd39;
            7'd41: ch = 7'd96;
            7'd43: ch = 7'd124;
            7'd44: ch = 7'd122;
            7'd45: ch = 7'd120;
            7'd46: ch = 7'd99;
            7'd47: ch = 7'd118;
            7'd48: ch = 7'd98;
            7'd49: ch = 7'd110;
            7'd50: ch = 7'd109;
            7'd51: ch = 7'd44;
            7'd52: ch = 7'd46;
            7'd53: ch = 7'd47;
            7'd55: ch = 7'd42;
            7'd57: ch = 7'd32;
            7'd74: ch = 7'd45;
            7'd78: ch = 7'd43;
            default: ch = CH_UNMAPPED;
        endcase
        return ch;
    endfunction

endpackage

// ===== design/scrb_char_ram.sv =====
module scrb_char_ram (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [scrb_pkg::PTR_W-1:0]    i_waddr,
    input  logic [scrb_pkg::CHAR_W-1:0]   i_wdata,
    input  logic                          i_re,
    input  logic [scrb_pkg::PTR_W-1:0]    i_raddr,
    output logic [scrb_pkg::CHAR_W-1:0]   o_rdata
);

    logic [scrb_pkg::CHAR_W-1:0] r_mem [scrb_pkg::BUF_DEPTH];
    logic [scrb_pkg::CHAR_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/scrb_ctrl.sv =====
module scrb_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  scrb_pkg::t_func               i_func,
    input  logic [scrb_pkg::CODE_W-1:0]   i_scan_code,
    output scrb_pkg::t_mem_req            o_mem_req,
    output scrb_pkg::t_step_res           o_res
);

    logic [scrb_pkg::PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [scrb_pkg::PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [scrb_pkg::PTR_W-1:0] r_pk_ptr, n_pk_ptr;
    logic [scrb_pkg::CNT_W-1:0] r_count,  n_count;

    logic [scrb_pkg::CHAR_W-1:0] ch;
    logic [scrb_pkg::PTR_W-1:0]  wr_prev;
    logic                        ring_full;
    logic                        ring_empty;
    logic                        pk_occupied;

    // occupied slots are exactly read_ptr up to write_ptr, so the fill count
    // tells whether any slot holds a character without touching the memory
    assign ch          = scrb_pkg::translate(i_scan_code[scrb_pkg::CHAR_W-1:0]);
    assign wr_prev     = scrb_pkg::ptr_prev(r_wr_ptr);
    assign ring_full   = (r_count == scrb_pkg::CNT_W'(scrb_pkg::BUF_DEPTH));
    assign ring_empty  = (r_count == '0);
    assign pk_occupied = (scrb_pkg::CNT_W'(scrb_pkg::ptr_dist(r_pk_ptr, r_rd_ptr)) < r_count);

    // request decode and next pointer values
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_pk_ptr = r_pk_ptr;
        n_count  = r_count;

        o_mem_req.we    = 1'b0;
        o_mem_req.waddr = r_wr_ptr;
        o_mem_req.wdata = ch;
        o_mem_req.re    = 1'b0;
        o_mem_req.raddr = r_rd_ptr;

        o_res.status  = scrb_pkg::STAT_INVALID;
        o_res.key_hit = 1'b0;

        unique case (i_func)
            scrb_pkg::FUNC_SCAN: begin
                if (i_scan_code[scrb_pkg::CODE_W-1]) begin
                    o_res.status = scrb_pkg::STAT_INVALID;
                end else if (ring_full) begin
                    o_res.status = scrb_pkg::STAT_FULL;
                end else if (ch == scrb_pkg::CH_BS) begin
                    // take back the newest unconsumed character
                    o_res.status = scrb_pkg::STAT_DELETED;
                    if (!ring_empty) begin
                        n_wr_ptr = wr_prev;
                        n_count  = r_count - scrb_pkg::CNT_W'(1);
                        if (r_pk_ptr == r_wr_ptr) begin
                            n_pk_ptr = wr_prev;
                        end
                    end
                end else if (ch != scrb_pkg::CH_UNMAPPED) begin
                    o_res.status = scrb_pkg::STAT_STORED;
                    o_mem_req.we = i_accept;
                    n_wr_ptr     = scrb_pkg::ptr_next(r_wr_ptr);
                    n_count      = r_count + scrb_pkg::CNT_W'(1);
                end else begin
                    o_res.status = scrb_pkg::STAT_UNMAPPED;
                end
            end
            scrb_pkg::FUNC_CONSUME: begin
                o_mem_req.re    = i_accept;
                o_mem_req.raddr = r_rd_ptr;
                o_res.key_hit   = !ring_empty;
                if (!ring_empty) begin
                    n_rd_ptr = scrb_pkg::ptr_next(r_rd_ptr);
                    n_count  = r_count - scrb_pkg::CNT_W'(1);
                    if (r_pk_ptr == r_rd_ptr) begin
                        n_pk_ptr = scrb_pkg::ptr_next(r_pk_ptr);
                    end
                end
            end
            scrb_pkg::FUNC_PEEK: begin
                o_mem_req.re    = i_accept;
                o_mem_req.raddr = r_pk_ptr;
                o_res.key_hit   = pk_occupied;
                if (pk_occupied) begin
                    n_pk_ptr = scrb_pkg::ptr_next(r_pk_ptr);
                end
            end
            scrb_pkg::FUNC_NONE: begin
                o_res.status = scrb_pkg::STAT_INVALID;
            end
            default: begin
                o_res.status = scrb_pkg::STAT_INVALID;
            end
        endcase

        o_res.key_avail = (n_count != '0);
    end

    // pointer and fill count registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_pk_ptr <= '0;
            r_count  <= '0;
        end else if (i_accept) begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_pk_ptr <= n_pk_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== design/scancode_key_ring_buffer.sv =====
// each result is registered in the pending fields and the ram read, then in the output register
// a request is taken only in idle state; the block stays busy until that result loads, longer on stall
// the next request is taken while the previous result waits on the output register
// reset: synchronous active-low i_rst_n clears pointers, fill count and handshake state
// the character ram needs no clearing pass; the fill count marks which slots hold data
module scancode_key_ring_buffer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] scan_code
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] func
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata    // [2:0] status, [9:3] key_char, [10] key_available
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_BUSY = 2'b10
    } t_state;

    t_state                          r_state, n_state;
    scrb_pkg::t_step_res             r_res;
    scrb_pkg::t_step_res             step_res;
    scrb_pkg::t_mem_req              mem_req;
    logic [scrb_pkg::CHAR_W-1:0]     rdata;
    logic                            r_out_valid;
    logic [scrb_pkg::OUT_DATA_W-1:0] r_out_data;
    logic [scrb_pkg::OUT_DATA_W-1:0] n_out_data;
    logic [scrb_pkg::CHAR_W-1:0]     key_char;
    logic                            accept;
    logic                            load_out;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign load_out        = (r_state == ST_BUSY) && (!r_out_valid || i_m_axis_tready);

    scrb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_func      (scrb_pkg::t_func'(i_s_axis_tuser)),
        .i_scan_code (i_s_axis_tdata),
        .o_mem_req   (mem_req),
        .o_res       (step_res)
    );

    scrb_char_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_re    (mem_req.re),
        .i_raddr (mem_req.raddr),
        .o_rdata (rdata)
    );

    // result word from pending fields and ram data
    assign key_char   = r_res.key_hit ? rdata : scrb_pkg::CH_NONE;
    assign n_out_data = {(scrb_pkg::OUT_DATA_W - scrb_pkg::STAT_W - scrb_pkg::CHAR_W - 1)'(0),
                         r_res.key_avail, key_char, r_res.status};

    // request sequencing
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_BUSY;
                end
            end
            ST_BUSY: begin
                if (load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // pending result fields
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= step_res;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

// ===== sim/key_ring_checker.sv =====
module key_ring_checker
    import scrb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  logic              i_req_ready,
    input  logic [CODE_W-1:0] i_req_code,
    input  logic [FUNC_W-1:0] i_req_func,
    input  logic              i_res_valid,
    input  logic              i_res_ready,
    input  logic [15:0]       i_res_data,   // [2:0] status, [9:3] key_char, [10] key_available
    output int                o_fail_cnt,
    output int                o_pending,
    output int                o_checked,
    output int                o_full_hits
);

    // characters for codes below 58, '?' fills the holes
    localparam byte NO_KEY = 8'h3f;

    typedef struct packed {
        t_status           status;
        logic [CHAR_W-1:0] key_char;
        logic              key_avail;
    } t_key_result;

    // own copy of the ring and its pointers
    logic [CHAR_W-1:0] ring [BUF_DEPTH];
    logic [PTR_W-1:0]  wr_ptr;
    logic [PTR_W-1:0]  rd_ptr;
    logic [PTR_W-1:0]  pk_ptr;
    t_key_result       expected_results [$];
    int                fail_cnt;
    int                checked;
    int                full_hits;

    // set-1 make code to ascii, CH_UNMAPPED where nothing is printable
    function automatic logic [CHAR_W-1:0] set1_char(input logic [CODE_W-1:0] code);
        string             keys;
        byte               b;
        logic [CHAR_W-1:0] ch;
        keys = "?\0331234567890-=\010\tqwertyuiop[]\n?asdfghjkl;'\140?|zxcvbnm,./?*? ";
        ch   = CH_UNMAPPED;
        if (code < 8'd58) begin
            b = keys.getc(int'(code));
            if (b != NO_KEY) begin
                ch = b[CHAR_W-1:0];
            end
        end else if (code == 8'd74) begin
            ch = 7'd45;     // keypad minus
        end else if (code == 8'd78) begin
            ch = 7'd43;     // keypad plus
        end
        return ch;
    endfunction

    // apply one request to the ring copy and return what the block should answer
    function automatic t_key_result step_key_ring(input t_func f, input logic [CODE_W-1:0] code);
        t_key_result       r;
        logic [CHAR_W-1:0] ch;
        logic [PTR_W-1:0]  prev;
        logic [PTR_W-1:0]  after_prev;
        r.status   = STAT_INVALID;
        r.key_char = CH_NONE;
        case (f)
            FUNC_SCAN: begin
                if (code >= 8'd128) begin
                    r.status = STAT_INVALID;
                end else if (ring[wr_ptr] != CH_NONE) begin
                    r.status = STAT_FULL;
                end else begin
                    ch = set1_char(code);
                    if (ch == CH_BS) begin
                        // take back the newest unconsumed character
                        prev       = wr_ptr - 1'b1;
                        after_prev = prev + 1'b1;
                        if (ring[prev] != CH_NONE) begin
                            ring[prev] = CH_NONE;
                            wr_ptr     = prev;
                            if (after_prev == pk_ptr) begin
                                pk_ptr = pk_ptr - 1'b1;
                            end
                        end
                        r.status = STAT_DELETED;
                    end else if (ch != CH_UNMAPPED) begin
                        ring[wr_ptr] = ch;
                        wr_ptr       = wr_ptr + 1'b1;
                        r.status     = STAT_STORED;
                    end else begin
                        r.status = STAT_UNMAPPED;
                    end
                end
            end
            FUNC_CONSUME: begin
                ch = ring[rd_ptr];
                if (ch != CH_NONE) begin
                    // peek is dragged along when it sits on the read slot
                    if (pk_ptr == rd_ptr) begin
                        pk_ptr = pk_ptr + 1'b1;
                    end
                    ring[rd_ptr] = CH_NONE;
                    rd_ptr       = rd_ptr + 1'b1;
                end
                r.key_char = ch;
            end
            FUNC_PEEK: begin
                ch = ring[pk_ptr];
                if (ch != CH_NONE) begin
                    pk_ptr = pk_ptr + 1'b1;
                end
                r.key_char = ch;
            end
            default: begin
            end
        endcase
        r.key_avail = (ring[rd_ptr] != CH_NONE);
        if (r.status == STAT_FULL && f == FUNC_SCAN) begin
            full_hits++;
        end
        return r;
    endfunction

    // watch both channels, compare results against the oldest prediction
    always @(posedge i_clk) begin
        t_key_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < BUF_DEPTH; i++) begin
                ring[i] = CH_NONE;
            end
            wr_ptr = '0;
            rd_ptr = '0;
            pk_ptr = '0;
            expected_results.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                checked++;
                if (expected_results.size() == 0) begin
                    $error("result %h arrived with no request outstanding", i_res_data);
                    fail_cnt++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_res_data[2:0] !== want.status) begin
                        $error("status expected %0d got %0d", want.status, i_res_data[2:0]);
                        fail_cnt++;
                    end
                    if (i_res_data[9:3] !== want.key_char) begin
                        $error("key_char expected %0d got %0d", want.key_char, i_res_data[9:3]);
                        fail_cnt++;
                    end
                    if (i_res_data[10] !== want.key_avail) begin
                        $error("key_available expected %0d got %0d",
                               want.key_avail, i_res_data[10]);
                        fail_cnt++;
                    end
                    if (i_res_data[15:11] !== 5'd0) begin
                        $error("tdata padding expected 0 got %0d", i_res_data[15:11]);
                        fail_cnt++;
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                expected_results.push_back(step_key_ring(t_func'(i_req_func), i_req_code));
            end
        end
        o_pending   <= expected_results.size();
        o_fail_cnt  <= fail_cnt;
        o_checked   <= checked;
        o_full_hits <= full_hits;
    end

endmodule

// ===== sim/testbench.sv =====
module testbench;
    import scrb_pkg::*;

    localparam int RANDOM_ITEMS = 800;
    localparam int FILL_ITEMS   = 330;

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_ANY
    } t_mix;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;     // [7:0] scan_code
    logic [1:0]  s_tuser  = FUNC_NONE; // [1:0] func
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;             // [2:0] status, [9:3] key_char, [10] key_available

    int fail_cnt;
    int pending;
    int checked;
    int full_hits;
    int sent;
    int sent_by_func [4];
    int burst_left;
    int stall_left;
    int stall_mode;
    int phase;

    always #1 clk = ~clk;

    scancode_key_ring_buffer DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    key_ring_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (s_tvalid),
        .i_req_ready (s_tready),
        .i_req_code  (s_tdata),
        .i_req_func  (s_tuser),
        .i_res_valid (m_tvalid),
        .i_res_ready (m_tready),
        .i_res_data  (m_tdata),
        .o_fail_cnt  (fail_cnt),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_full_hits (full_hits)
    );

    // receiver: switches between open, random, sparse and periodic acceptance
    always @(posedge clk) begin
        phase <= phase + 1;
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(50, 300);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= (phase[2:0] != 3'd5);
        endcase
    end

    // one request, held until taken; bursts end in a random gap, which may be zero
    task automatic send_request(input t_func f, input logic [CODE_W-1:0] code);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= code;
        sent++;
        sent_by_func[f]++;
        do @(posedge clk); while (!s_tready);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // mapped make code, never backspace
    function automatic logic [CODE_W-1:0] printable_code();
        logic [CODE_W-1:0] code;
        case ($urandom_range(0, 3))
            0: code = 8'($urandom_range(2, 13));
            1: code = 8'($urandom_range(15, 28));
            2: code = 8'($urandom_range(30, 41));
            default: code = 8'($urandom_range(44, 53));
        endcase
        return code;
    endfunction

    // any func and any byte
    task automatic send_noise();
        send_request(t_func'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    endtask

    task automatic send_random(input t_mix mix);
        int pick;
        pick = $urandom_range(0, 99);
        case (mix)
            MIX_FILL: begin
                if (pick < 88) send_request(FUNC_SCAN, printable_code());
                else if (pick < 91) send_request(FUNC_SCAN, 8'd14);
                else if (pick < 96) send_request(FUNC_PEEK, 8'($urandom_range(0, 255)));
                else send_noise();
            end
            MIX_DRAIN: begin
                if (pick < 70) send_request(FUNC_CONSUME, 8'($urandom_range(0, 255)));
                else if (pick < 85) send_request(FUNC_PEEK, 8'($urandom_range(0, 255)));
                else if (pick < 93) send_request(FUNC_SCAN, printable_code());
                else send_noise();
            end
            default: begin
                if (pick < 30) send_request(FUNC_SCAN, printable_code());
                else if (pick < 40) send_request(FUNC_SCAN, 8'd14);
                else if (pick < 60) send_request(FUNC_CONSUME, 8'($urandom_range(0, 255)));
                else if (pick < 75) send_request(FUNC_PEEK, 8'($urandom_range(0, 255)));
                else send_noise();
            end
        endcase
    endtask

    initial begin
        int seg_len;
        t_mix mix;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        burst_left = $urandom_range(1, 40);

        // empty ring, unused func, backspace with nothing to remove
        send_request(FUNC_CONSUME, 8'h00);
        send_request(FUNC_PEEK, 8'hff);
        send_request(FUNC_NONE, 8'haa);
        send_request(FUNC_SCAN, 8'd14);
        // out of range and unmapped codes
        send_request(FUNC_SCAN, 8'd128);
        send_request(FUNC_SCAN, 8'd255);
        send_request(FUNC_SCAN, 8'd0);
        send_request(FUNC_SCAN, 8'd127);
        send_request(FUNC_SCAN, 8'd89);
        send_request(FUNC_SCAN, 8'd88);
        send_request(FUNC_SCAN, 8'd29);
        // stored characters including escape, keypad and space
        send_request(FUNC_SCAN, 8'd1);
        send_request(FUNC_SCAN, 8'd74);
        send_request(FUNC_SCAN, 8'd78);
        send_request(FUNC_SCAN, 8'd57);
        // peek everything, then backspace pulls peek back
        repeat (4) send_request(FUNC_PEEK, 8'h55);
        send_request(FUNC_SCAN, 8'd14);
        send_request(FUNC_PEEK, 8'h00);
        // drain, then consume with peek on the read slot
        repeat (3) send_request(FUNC_CONSUME, 8'h80);
        send_request(FUNC_SCAN, 8'd30);
        send_request(FUNC_CONSUME, 8'h7f);

        // long fill so the ring runs into full and pointers wrap
        sent = 0;
        for (int i = 0; i < FILL_ITEMS; i++) begin
            send_random(MIX_FILL);
        end
        while (sent < RANDOM_ITEMS) begin
            seg_len = $urandom_range(10, 80);
            mix     = t_mix'($urandom_range(0, 2));
            for (int i = 0; i < seg_len; i++) begin
                send_random(mix);
            end
        end
        s_tvalid <= 1'b0;

        do @(posedge clk); while (pending != 0);
        repeat (8) @(posedge clk);

        $display("random part sent %0d requests; all told %0d scans, %0d consumes, %0d peeks, %0d unused",
                 sent, sent_by_func[FUNC_SCAN], sent_by_func[FUNC_CONSUME],
                 sent_by_func[FUNC_PEEK], sent_by_func[FUNC_NONE]);
        $display("%0d results compared, %0d scans refused on a full ring", checked, full_hits);
        if (fail_cnt == 0) begin
            $display("PASS scancode_key_ring_buffer");
        end else begin
            $display("FAIL scancode_key_ring_buffer");
        end
        $finish;
    end

    // hang guard
    initial begin
        #1000000;
        $display("FAIL scancode_key_ring_buffer");
        $finish;
    end

endmodule
